@@ hw/rtl/circular_fifo_with_high_water_mark_defines.svh @@
`ifndef CIRCULAR_FIFO_WITH_HIGH_WATER_MARK_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_HIGH_WATER_MARK_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define CFHWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define CFHWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cfhwm_pkg.sv @@
package cfhwm_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int REQ_W    = 3;
    localparam int DIN_W    = 32;
    localparam int DOUT_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;
    localparam int OUT_BITS = DOUT_W + 2 * COUNT_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [REQ_W-1:0] REQ_ENQ   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUMP  = 3'd4;

    localparam int CMDQ_DEPTH = 2;
    localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
    localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ENQ,
        OP_DEQ,
        OP_PEEK,
        OP_CLEAR,
        OP_DUMP,
        OP_BAD
    } op_t;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        op_t   op;
        word_t word;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [DOUT_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] high;
        logic               last;
    } res_t;

    function automatic word_t to_word(input logic [DIN_W-1:0] din);
        word_t w;
        w = '0;
        for (int i = 0; i < DATA_WIDTH; i++) begin
            if (i < DIN_W) begin
                w[i] = din[i];
            end
        end
        return w;
    endfunction

    function automatic logic [DOUT_W-1:0] to_out(input word_t w);
        logic [DOUT_W-1:0] r;
        r = '0;
        for (int i = 0; i < DOUT_W; i++) begin
            if (i < DATA_WIDTH) begin
                r[i] = w[i];
            end
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        if (cap == '0) begin
            return CNT_W'(1);
        end
        if (cap > CAP_W'(DEPTH)) begin
            return CNT_W'(DEPTH);
        end
        return CNT_W'(cap);
    endfunction

    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  cap);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + CNT_W'(1);
        if (nxt >= cap) begin
            return '0;
        end
        return nxt[ADDR_W-1:0];
    endfunction

endpackage

@@ hw/rtl/cfhwm_front.sv @@
module cfhwm_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cfhwm_pkg::DIN_W-1:0]  s_tdata,
    input  logic [cfhwm_pkg::REQ_W-1:0]  s_tuser,
    output logic                         push_valid,
    input  logic                         push_ready,
    output cfhwm_pkg::cmd_t              push_cmd
);
    import cfhwm_pkg::*;

    op_t op;

    always_comb begin
        unique case (s_tuser)
            REQ_ENQ:   op = OP_ENQ;
            REQ_DEQ:   op = OP_DEQ;
            REQ_PEEK:  op = OP_PEEK;
            REQ_CLEAR: op = OP_CLEAR;
            REQ_DUMP:  op = OP_DUMP;
            default:   op = OP_BAD;
        endcase
    end

    assign s_tready      = push_ready;
    assign push_valid    = s_tvalid;
    assign push_cmd.op   = op;
    assign push_cmd.word = (op == OP_ENQ) ? to_word(s_tdata) : '0;

endmodule

@@ hw/rtl/cfhwm_cmdq.sv @@
module cfhwm_cmdq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  cfhwm_pkg::cmd_t in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output cfhwm_pkg::cmd_t out_cmd
);
    import cfhwm_pkg::*;

    cmd_t              entry_reg [CMDQ_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push, pop;

    assign in_ready  = (fill_reg != QCNT_W'(CMDQ_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ hw/rtl/cfhwm_back.sv @@
module cfhwm_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [cfhwm_pkg::CAP_W-1:0] capacity,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  cfhwm_pkg::cmd_t             cmd,
    output logic                        res_valid,
    input  logic                        res_ready,
    output cfhwm_pkg::res_t             res
);
    import cfhwm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DUMP = 2'd2;

    word_t             mem [DEPTH];
    word_t             rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    logic [1:0]        state_reg, state_next;
    op_t               op_reg, op_next;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0] dump_idx_reg, dump_idx_next;
    logic [CNT_W-1:0]  dump_left_reg, dump_left_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  peak_reg, peak_next;
    logic              valid_reg, valid_next;
    res_t              res_reg, res_next;

    logic              out_free;
    logic              emit;
    logic              emit_ok;
    logic              emit_last;
    logic [DOUT_W-1:0] emit_data;
    logic [CNT_W-1:0]  cap_eff;

    assign cap_eff  = eff_cap(capacity);
    assign out_free = !valid_reg || res_ready;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        dump_idx_next  = dump_idx_reg;
        dump_left_next = dump_left_reg;
        count_next     = count_reg;
        peak_next      = peak_reg;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = rd_idx_reg;
        emit           = 1'b0;
        emit_ok        = 1'b0;
        emit_last      = 1'b1;
        emit_data      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    unique case (cmd.op)
                        OP_ENQ: begin
                            cmd_ready = 1'b1;
                            emit      = 1'b1;
                            if (count_reg < cap_eff) begin
                                wr_en       = 1'b1;
                                emit_ok     = 1'b1;
                                wr_idx_next = advance(wr_idx_reg, cap_eff);
                                count_next  = count_reg + 1'b1;
                                if (count_next > peak_reg) begin
                                    peak_next = count_next;
                                end
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            cmd_ready = 1'b1;
                            if (count_reg != '0) begin
                                op_next    = cmd.op;
                                state_next = ST_READ;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            cmd_ready   = 1'b1;
                            emit        = 1'b1;
                            emit_ok     = 1'b1;
                            wr_idx_next = '0;
                            rd_idx_next = '0;
                            count_next  = '0;
                        end
                        OP_DUMP: begin
                            cmd_ready = 1'b1;
                            if (count_reg != '0) begin
                                dump_idx_next  = rd_idx_reg;
                                dump_left_next = count_reg;
                                state_next     = ST_DUMP;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        default: begin
                            cmd_ready = 1'b1;
                            emit      = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_ok    = 1'b1;
                    emit_data  = to_out(rd_data_reg);
                    state_next = ST_IDLE;
                    if (op_reg == OP_DEQ) begin
                        rd_idx_next = advance(rd_idx_reg, cap_eff);
                        count_next  = count_reg - 1'b1;
                    end
                end
            end
            ST_DUMP: begin
                rd_addr = dump_idx_reg;
                if (out_free) begin
                    emit           = 1'b1;
                    emit_ok        = 1'b1;
                    emit_data      = to_out(rd_data_reg);
                    emit_last      = (dump_left_reg == CNT_W'(1));
                    dump_idx_next  = advance(dump_idx_reg, cap_eff);
                    dump_left_next = dump_left_reg - 1'b1;
                    rd_addr        = dump_idx_next;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (emit) begin
            valid_next     = 1'b1;
            res_next.ok    = emit_ok;
            res_next.data  = emit_data;
            res_next.count = COUNT_W'(count_next);
            res_next.high  = COUNT_W'(peak_next);
            res_next.last  = emit_last;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_BAD;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            dump_idx_reg  <= '0;
            dump_left_reg <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            dump_idx_reg  <= dump_idx_next;
            dump_left_reg <= dump_left_next;
            count_reg     <= count_next;
            peak_reg      <= peak_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx_reg] <= cmd.word;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

@@ hw/rtl/circular_fifo_with_high_water_mark.sv @@
// Circular FIFO of 32-bit words with a high-water mark of the fill count.
// Requests enter on the s_ stream: s_tuser carries the request kind
// (enqueue, dequeue, peek, clear, dump) and s_tdata the word to enqueue.
// Results leave on the m_ stream; m_tlast marks the final result of a
// request, m_tuser carries the success flag.
// The cfg_ channel writes the capacity at which the pointers wrap; write it
// only while no request is in flight.
// Enqueue, clear and refused requests are answered from the request queue
// straight into the output register; dequeue and peek first wait on the
// registered read of the storage array. Enqueue and clear sustain one request
// per cycle while m_tready stays high, but a dequeue or peek holds off the next
// request until its result is emitted, and a dump of N entries streams N words,
// one per cycle while m_tready stays high, from the array's single read port.
// Reset clears the pointers, the count, the high-water mark and the request
// queue and sets the capacity to 64; stored words are undefined until written.
// When the receiver holds m_tready low the result stays in the output
// register, the request queue fills and s_tready drops.
`include "circular_fifo_with_high_water_mark_defines.svh"

module circular_fifo_with_high_water_mark (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // data_in
    input  logic [cfhwm_pkg::DIN_W-1:0]      s_tdata,
    // req_type
    input  logic [cfhwm_pkg::REQ_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // data_out, count, high_mark, zero padding
    output logic [cfhwm_pkg::M_TDATA_W-1:0]  m_tdata,
    // ok
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cfhwm_pkg::CAP_W-1:0]      cfg_data
);
    import cfhwm_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic             push_valid, push_ready;
    cmd_t             push_cmd;
    logic             cmd_valid, cmd_ready;
    cmd_t             cmd;
    res_t             res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    cfhwm_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    cfhwm_cmdq u_cmdq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_cmd   (cmd)
    );

    cfhwm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .capacity  (cap_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_BITS){1'b0}}, res.high, res.count, res.data};
    assign m_tuser = res.ok;
    assign m_tlast = res.last;

    `CFHWM_ASSERT_NOW(a_high_covers_count, m_tvalid, res.high >= res.count, "high mark below count")
    `CFHWM_ASSERT_NOW(a_fail_is_single, m_tvalid && !res.ok, res.last && res.data == '0, "bad failure result")
    `CFHWM_ASSERT_NOW(a_count_bounded, m_tvalid, res.count <= COUNT_W'(DEPTH), "count exceeds depth")
    `CFHWM_ASSERT_NEXT(a_stall_holds_queue, m_tvalid && !m_tready && !push_ready, !push_ready, "queue drained under stall")

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import cfhwm_pkg::*;

    localparam logic [REQ_W-1:0] REQ_BAD_LO  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_BAD_MID = 3'd6;
    localparam logic [REQ_W-1:0] REQ_BAD_HI  = 3'd7;
    localparam int VECTOR_COUNT = 24;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 35;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [DIN_W-1:0] word;
        logic             typed;
        res_t             want;
    } vector_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DIN_W-1:0]       s_tdata = '0;
    logic [REQ_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data = '0;

    logic [DATA_WIDTH-1:0]  ring_words [DEPTH];
    logic [ADDR_W-1:0]      head_ptr;
    logic [ADDR_W-1:0]      tail_ptr;
    logic [COUNT_W-1:0]     fill_level;
    logic [COUNT_W-1:0]     peak_level;
    logic [CAP_W-1:0]       cap_setting;

    res_t fresh_results [$];
    res_t awaited_results [$];
    int   kind_seen [8];
    int   results_checked = 0;
    int   mismatches = 0;
    int   caps_written = 0;
    bit   quiet_phase = 1'b0;

    vector_t directed_vectors [VECTOR_COUNT] = '{
        '{REQ_PEEK,    32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{REQ_DEQ,     32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{REQ_DUMP,    32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{REQ_BAD_LO,  32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{REQ_BAD_MID, 32'h5555_AAAA, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{REQ_BAD_HI,  32'hAAAA_5555, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{REQ_CLEAR,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 7'd0, 7'd0, 1'b1}},
        '{REQ_ENQ,     32'h0000_0000, 1'b1, '{1'b1, 32'h0, 7'd1, 7'd1, 1'b1}},
        '{REQ_ENQ,     32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 7'd2, 7'd2, 1'b1}},
        '{REQ_ENQ,     32'hA5A5_5A5A, 1'b1, '{1'b1, 32'h0, 7'd3, 7'd3, 1'b1}},
        '{REQ_PEEK,    32'h1234_5678, 1'b1, '{1'b1, 32'h0, 7'd3, 7'd3, 1'b1}},
        '{REQ_DUMP,    32'h0000_0000, 1'b0, '0},
        '{REQ_DEQ,     32'h0000_0000, 1'b1, '{1'b1, 32'h0, 7'd2, 7'd3, 1'b1}},
        '{REQ_PEEK,    32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 7'd2, 7'd3, 1'b1}},
        '{REQ_DEQ,     32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 7'd1, 7'd3, 1'b1}},
        '{REQ_ENQ,     32'h1234_5678, 1'b1, '{1'b1, 32'h0, 7'd2, 7'd3, 1'b1}},
        '{REQ_CLEAR,   32'h0000_0000, 1'b1, '{1'b1, 32'h0, 7'd0, 7'd3, 1'b1}},
        '{REQ_DEQ,     32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd3, 1'b1}},
        '{REQ_DUMP,    32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd0, 7'd3, 1'b1}},
        '{REQ_ENQ,     32'h8000_0001, 1'b1, '{1'b1, 32'h0, 7'd1, 7'd3, 1'b1}},
        '{REQ_DUMP,    32'h0000_0000, 1'b0, '0},
        '{REQ_DEQ,     32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0001, 7'd0, 7'd3, 1'b1}},
        '{REQ_ENQ,     32'h7FFF_FFFE, 1'b0, '0},
        '{REQ_BAD_HI,  32'h0000_0000, 1'b1, '{1'b0, 32'h0, 7'd1, 7'd3, 1'b1}}
    };

    circular_fifo_with_high_water_mark u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int live_capacity();
        if (cap_setting == 0) begin
            return 1;
        end
        if (cap_setting > DEPTH) begin
            return DEPTH;
        end
        return int'(cap_setting);
    endfunction

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] idx);
        int nxt;
        nxt = int'(idx) + 1;
        if (nxt >= live_capacity()) begin
            return '0;
        end
        return ADDR_W'(nxt);
    endfunction

    function automatic void note_result(input logic ok, input logic [DOUT_W-1:0] data,
                                        input logic last);
        res_t r;
        r.ok = ok;
        r.data = data;
        r.count = fill_level;
        r.high = peak_level;
        r.last = last;
        fresh_results.push_back(r);
    endfunction

    function automatic void predict_fifo_response(input logic [REQ_W-1:0] req,
                                                  input logic [DIN_W-1:0] word);
        logic [ADDR_W-1:0] idx;
        int n;
        case (req)
            REQ_ENQ: begin
                if (fill_level < live_capacity()) begin
                    ring_words[tail_ptr] = word;
                    tail_ptr = ring_next(tail_ptr);
                    fill_level = fill_level + 1'b1;
                    if (fill_level > peak_level) begin
                        peak_level = fill_level;
                    end
                    note_result(1'b1, '0, 1'b1);
                end else begin
                    note_result(1'b0, '0, 1'b1);
                end
            end
            REQ_DEQ: begin
                if (fill_level != 0) begin
                    idx = head_ptr;
                    head_ptr = ring_next(head_ptr);
                    fill_level = fill_level - 1'b1;
                    note_result(1'b1, ring_words[idx], 1'b1);
                end else begin
                    note_result(1'b0, '0, 1'b1);
                end
            end
            REQ_PEEK: begin
                if (fill_level != 0) begin
                    note_result(1'b1, ring_words[head_ptr], 1'b1);
                end else begin
                    note_result(1'b0, '0, 1'b1);
                end
            end
            REQ_CLEAR: begin
                head_ptr = '0;
                tail_ptr = '0;
                fill_level = '0;
                note_result(1'b1, '0, 1'b1);
            end
            REQ_DUMP: begin
                if (fill_level == 0) begin
                    note_result(1'b0, '0, 1'b1);
                end else begin
                    idx = head_ptr;
                    n = int'(fill_level);
                    for (int i = 0; i < n; i++) begin
                        note_result(1'b1, ring_words[idx], i == n - 1);
                        idx = ring_next(idx);
                    end
                end
            end
            default: begin
                note_result(1'b0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [DIN_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue_request(input logic [REQ_W-1:0] req, input logic [DIN_W-1:0] word,
                                 input logic typed, input res_t want);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= req;
        do @(posedge aclk); while (!s_tready);
        kind_seen[req]++;
        fresh_results.delete();
        predict_fifo_response(req, word);
        if (typed) begin
            awaited_results.push_back(want);
        end else begin
            foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
        end
    endtask

    task automatic settle_fifo();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_setting = value;
        caps_written++;
    endtask

    task automatic flag_field(input string name, input logic [DOUT_W-1:0] want,
                              input logic [DOUT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 50) begin
                $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
                         $time, name, want, got);
            end
        end
    endtask

    initial begin
        res_t want;
        int stall;
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            results_checked++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 50) begin
                    $display("%0t: unexpected transaction, expected none, actual data 'h%0h",
                             $time, m_tdata[DOUT_W-1:0]);
                end
            end else begin
                want = awaited_results.pop_front();
                flag_field("ok", DOUT_W'(want.ok), DOUT_W'(m_tuser[0]));
                flag_field("data_out", want.data, m_tdata[DOUT_W-1:0]);
                flag_field("count", DOUT_W'(want.count), DOUT_W'(m_tdata[DOUT_W +: COUNT_W]));
                flag_field("high_mark", DOUT_W'(want.high),
                           DOUT_W'(m_tdata[DOUT_W + COUNT_W +: COUNT_W]));
                flag_field("last", DOUT_W'(want.last), DOUT_W'(m_tlast));
            end
        end
    end

    initial begin
        logic [CAP_W-1:0] cap_plan [PHASE_COUNT];
        logic [REQ_W-1:0] req;
        int pick;
        int enq_pct;

        head_ptr = '0;
        tail_ptr = '0;
        fill_level = '0;
        peak_level = '0;
        cap_setting = CAP_RESET;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        cap_plan = '{7'd0, 7'd127, 7'd1, 7'd65, 7'd64, 7'd2, 7'd0, 7'd3};
        cap_plan[6] = CAP_W'($urandom_range(4, 63));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < VECTOR_COUNT; i++) begin
            issue_request(directed_vectors[i].req, directed_vectors[i].word,
                          directed_vectors[i].typed, directed_vectors[i].want);
        end
        settle_fifo();

        // Fill every slot once so that later capacity changes never expose
        // a slot that was not written since reset.
        issue_request(REQ_CLEAR, '0, 1'b0, '0);
        for (int i = 0; i < DEPTH; i++) begin
            issue_request(REQ_ENQ, pick_word(), 1'b0, '0);
        end
        issue_request(REQ_ENQ, pick_word(), 1'b0, '0);
        issue_request(REQ_DUMP, '0, 1'b0, '0);
        issue_request(REQ_PEEK, '0, 1'b0, '0);
        settle_fifo();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_capacity(cap_plan[p]);
            quiet_phase = ($urandom_range(0, 3) == 0);
            enq_pct = $urandom_range(35, 52);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < enq_pct) begin
                    req = REQ_ENQ;
                end else if (pick < enq_pct + 25) begin
                    req = REQ_DEQ;
                end else if (pick < enq_pct + 33) begin
                    req = REQ_PEEK;
                end else if (pick < enq_pct + 40) begin
                    req = REQ_DUMP;
                end else if (pick < enq_pct + 44) begin
                    req = REQ_CLEAR;
                end else begin
                    req = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
                end
                issue_request(req, pick_word(), 1'b0, '0);
            end
            settle_fifo();
        end
        quiet_phase = 1'b0;
        repeat (70) @(posedge aclk);

        $display("Run covered %0d enqueue, %0d dequeue, %0d peek, %0d clear, %0d dump requests",
                 kind_seen[REQ_ENQ], kind_seen[REQ_DEQ], kind_seen[REQ_PEEK],
                 kind_seen[REQ_CLEAR], kind_seen[REQ_DUMP]);
        $display("plus %0d unknown ones, %0d capacity writes, %0d results checked, %0d mismatches.",
                 kind_seen[REQ_BAD_LO] + kind_seen[REQ_BAD_MID] + kind_seen[REQ_BAD_HI],
                 caps_written, results_checked, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: run timed out with %0d results outstanding",
                 $time, awaited_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cfhwm_pkg.sv
hw/rtl/cfhwm_front.sv
hw/rtl/cfhwm_cmdq.sv
hw/rtl/cfhwm_back.sv
hw/rtl/circular_fifo_with_high_water_mark.sv
bench/testbench.sv
